FILE: hdl/lzwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

   localparam int unsigned CODE_W    = 12;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned NUM_ROOTS = 13;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_EXPAND = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_TOOLONG = 2'd2,
      ST_UNDEF   = 2'd3
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic [CHAR_W-1:0] first_char;
      logic [CODE_W-1:0] new_code;
      status_type        status;
      logic              last;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type            op;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] symbol;
   } cmd_type;

   // fixed root alphabet: digits, newline, space, minus
   function automatic logic [CHAR_W-1:0] root_char(input logic [3:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
         4'd5, 4'd6, 4'd7, 4'd8, 4'd9: ch = 8'h30 + {4'h0, idx};
         4'd10:                        ch = 8'h0a;
         4'd11:                        ch = 8'h20;
         4'd12:                        ch = 8'h2d;
         default:                      ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/lzwd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  lzwd_pkg::req_type     req_data,
   output logic                  busy,
   output logic                  cmd_valid,
   output lzwd_pkg::cmd_type     cmd,
   input  wire logic             cmd_pop
);

   // two-entry command queue
   lzwd_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;
   lzwd_pkg::cmd_type new_cmd;

   assign busy      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.op     = req_data.kind ? lzwd_pkg::OP_EXPAND : lzwd_pkg::OP_ADD;
      new_cmd.code   = req_data.code;
      new_cmd.symbol = req_data.symbol;
      wr_ptr_in      = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in      = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in       = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/lzwd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwd_back #(
   parameter int TABLE_DEPTH = 4096,
   parameter int MAX_STRING  = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  lzwd_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   output lzwd_pkg::rsp_type     rsp_data
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int NW  = $clog2(TABLE_DEPTH + 1);
   localparam int CW  = (NW > 12) ? NW : 12;
   localparam int SW  = $clog2(MAX_STRING);
   localparam int DW  = $clog2(MAX_STRING + 1);

   typedef struct packed {
      logic [lzwd_pkg::CODE_W-1:0] prefix;
      logic [lzwd_pkg::CHAR_W-1:0] chr;
   } entry_type;

   typedef enum logic [2:0] {
      IDLE,
      WALK,
      WAIT,
      EMIT_RD,
      EMIT_OUT
   } state_type;

   // entries below the roots never get written, roots come from the package
   entry_type                    tbl_mem [TABLE_DEPTH];
   entry_type                    tbl_q_ff;
   logic                         tbl_we;
   entry_type                    tbl_wdata;

   logic [lzwd_pkg::CHAR_W-1:0]  stk_mem [MAX_STRING];
   logic [lzwd_pkg::CHAR_W-1:0]  stk_q_ff;
   logic                         stk_we;
   logic [lzwd_pkg::CHAR_W-1:0]  stk_wdata;

   state_type                    state_ff, state_in;
   logic [NW-1:0]                nfc_ff, nfc_in;
   logic [AW-1:0]                cur_ff, cur_in;
   logic [DW-1:0]                depth_ff, depth_in;
   logic [SW-1:0]                ptr_ff, ptr_in;
   logic [lzwd_pkg::CHAR_W-1:0]  first_ff, first_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lzwd_pkg::rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]                code_ext;
   logic [CW-1:0]                nfc_ext;
   logic [lzwd_pkg::CHAR_W-1:0]  root_ch;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign code_ext  = CW'(cmd.code);
   assign nfc_ext   = CW'(nfc_ff);
   assign root_ch   = lzwd_pkg::root_char(cur_ff[3:0]);

   always_comb begin
      state_in     = state_ff;
      nfc_in       = nfc_ff;
      cur_in       = cur_ff;
      depth_in     = depth_ff;
      ptr_in       = ptr_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      tbl_we       = 1'b0;
      tbl_wdata    = '{prefix: cmd.code, chr: cmd.symbol};
      stk_we       = 1'b0;
      stk_wdata    = tbl_q_ff.chr;

      unique case (state_ff)
         IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               rsp_in  = '0;
               rsp_in.last = 1'b1;
               if (cmd.op == lzwd_pkg::OP_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (nfc_ff == NW'(TABLE_DEPTH)) begin
                     rsp_in.status = lzwd_pkg::ST_FULL;
                  end else if (code_ext >= nfc_ext) begin
                     rsp_in.status = lzwd_pkg::ST_UNDEF;
                  end else begin
                     tbl_we          = 1'b1;
                     rsp_in.status   = lzwd_pkg::ST_OK;
                     rsp_in.new_code = 12'(nfc_ext);
                     nfc_in          = nfc_ff + 1'b1;
                  end
               end else begin
                  if (code_ext >= nfc_ext) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = lzwd_pkg::ST_UNDEF;
                  end else begin
                     cur_in   = AW'(code_ext);
                     depth_in = '0;
                     state_in = WALK;
                  end
               end
            end
         end
         WALK: begin
            if (depth_ff == DW'(MAX_STRING)) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = lzwd_pkg::ST_TOOLONG;
               rsp_in.last   = 1'b1;
               state_in      = IDLE;
            end else if (cur_ff < AW'(lzwd_pkg::NUM_ROOTS)) begin
               stk_we    = 1'b1;
               stk_wdata = root_ch;
               first_in  = root_ch;
               ptr_in    = depth_ff[SW-1:0];
               state_in  = EMIT_RD;
            end else begin
               state_in = WAIT;
            end
         end
         WAIT: begin
            stk_we   = 1'b1;
            depth_in = depth_ff + 1'b1;
            cur_in   = AW'(CW'(tbl_q_ff.prefix));
            state_in = WALK;
         end
         EMIT_RD: begin
            state_in = EMIT_OUT;
         end
         EMIT_OUT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.out_char   = stk_q_ff;
            rsp_in.first_char = first_ff;
            rsp_in.new_code   = '0;
            rsp_in.status     = lzwd_pkg::ST_OK;
            rsp_in.last       = (ptr_ff == '0);
            if (ptr_ff == '0) begin
               state_in = IDLE;
            end else begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = EMIT_RD;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         nfc_ff       <= NW'(lzwd_pkg::NUM_ROOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nfc_ff       <= nfc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff   <= cur_in;
      depth_ff <= depth_in;
      ptr_ff   <= ptr_in;
      first_ff <= first_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[AW'(nfc_ff)] <= tbl_wdata;
      end
      tbl_q_ff <= tbl_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[depth_ff[SW-1:0]] <= stk_wdata;
      end
      stk_q_ff <= stk_mem[ptr_ff];
   end

endmodule

`default_nettype wire

FILE: hdl/lzw_decode_string_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                        direction  flow control
// request   start, busy, req_data        in         taken when start and not busy
// response  rsp_valid, rsp_data          out        one-cycle strobe, no backpressure
//
// add: result passes the command queue and the response register, with the queue empty
// expand of an n-character string: the last result is paced by the table read
//   (WALK, then WAIT) per chain step and by the stack read (EMIT_RD, then EMIT_OUT)
//   per character
// reset clears the queue, the sequencer and the free-code counter (back to 13)
// busy rises only when the two-entry command queue is full

module lzw_decode_string_table #(
   parameter int TABLE_DEPTH = 4096,
   parameter int MAX_STRING  = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  lzwd_pkg::req_type     req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output lzwd_pkg::rsp_type     rsp_data
);

   // classified commands waiting for the back end
   logic              cmd_valid;
   lzwd_pkg::cmd_type cmd;
   logic              cmd_pop;

   // front end: takes the transaction, decodes kind, queues it
   lzwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back end: string table, output stack and chain-walk sequencer
   lzwd_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_STRING  (MAX_STRING)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
